FILE: sv/rtc_pkg.sv
// rtc_pkg: shared types, widths, command and status codes of the radio tuner controller
// used by rtc_core, radio_tuner_controller_top and rtc_checker
// no dependencies
package rtc_pkg;

    localparam int STATION_W  = 11;
    localparam int VOL_W      = 7;
    localparam int STEP_W     = 6;
    localparam int REQ_W      = 4;
    localparam int IDX_W      = 4;
    localparam int VREQ_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 4;
    localparam int M_TDATA_W  = 24;

    // command codes
    localparam logic [REQ_W-1:0] REQ_POWER  = 4'd0;
    localparam logic [REQ_W-1:0] REQ_VOLUME = 4'd1;
    localparam logic [REQ_W-1:0] REQ_BAND   = 4'd2;
    localparam logic [REQ_W-1:0] REQ_STORE  = 4'd3;
    localparam logic [REQ_W-1:0] REQ_RECALL = 4'd4;
    localparam logic [REQ_W-1:0] REQ_UP     = 4'd5;
    localparam logic [REQ_W-1:0] REQ_DOWN   = 4'd6;
    localparam logic [REQ_W-1:0] REQ_TUNE   = 4'd7;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 4'd8;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HIGH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJ  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AM_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AM_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AM_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FM_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FM_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FM_STEP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_MAX = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_INIT = 3'd7;

    // reset values
    localparam logic [STATION_W-1:0] AM_LOW_RST     = 11'd530;
    localparam logic [STATION_W-1:0] AM_HIGH_RST    = 11'd1700;
    localparam logic [STEP_W-1:0]    AM_STEP_RST    = 6'd10;
    localparam logic [STATION_W-1:0] FM_LOW_RST     = 11'd879;
    localparam logic [STATION_W-1:0] FM_HIGH_RST    = 11'd1079;
    localparam logic [STEP_W-1:0]    FM_STEP_RST    = 6'd2;
    localparam logic [VOL_W-1:0]     VOLUME_MAX_RST = 7'd100;

    typedef struct packed {
        logic [STATION_W-1:0] am_low;
        logic [STATION_W-1:0] am_high;
        logic [STEP_W-1:0]    am_step;
        logic [STATION_W-1:0] fm_low;
        logic [STATION_W-1:0] fm_high;
        logic [STEP_W-1:0]    fm_step;
        logic [VOL_W-1:0]     volume_max;
    } rtc_cfg_t;

    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic [VREQ_W-1:0]    volume_value;
        logic [IDX_W-1:0]     preset_index;
        logic [STATION_W-1:0] station_value;
    } rtc_cmd_t;

    typedef struct packed {
        logic                 powered;
        logic                 band_fm;
        logic [STATION_W-1:0] station;
        logic [VOL_W-1:0]     volume_now;
        logic [STATUS_W-1:0]  status;
    } rtc_res_t;

endpackage

FILE: sv/rtc_core.sv
// rtc_core: tuner state (power, band, station, volume, presets) and its per-command update
// one command is applied per cmd_fire; res_next is the word for that command
// depends on rtc_pkg
module rtc_core #(
    parameter int PRESET_COUNT = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rtc_pkg::rtc_cfg_t cfg,
    input  logic             cmd_fire,
    input  rtc_pkg::rtc_cmd_t cmd,
    output rtc_pkg::rtc_res_t res_next
);
    import rtc_pkg::*;

    localparam int PIDX_W = (PRESET_COUNT > 1) ? $clog2(PRESET_COUNT) : 1;

    logic                 power_reg, power_next;
    logic                 band_reg, band_next;
    logic [STATION_W-1:0] station_reg, station_next;
    logic [VOL_W-1:0]     volume_reg, volume_next;
    logic [VOL_W-1:0]     saved_vol_reg, saved_vol_next;
    logic [STATION_W-1:0] last_am_reg, last_am_next;
    logic [STATION_W-1:0] last_fm_reg, last_fm_next;
    logic [STATION_W-1:0] am_preset_reg [PRESET_COUNT];
    logic [STATION_W-1:0] fm_preset_reg [PRESET_COUNT];

    logic [STATION_W-1:0] lo, hi, last_cur, last_other, preset_rd;
    logic [STEP_W-1:0]    step;
    logic [STATION_W:0]   up_sum;
    logic                 idx_ok;
    logic [PIDX_W-1:0]    pidx;
    logic                 preset_we;
    logic [STATUS_W-1:0]  status;
    logic signed [VREQ_W-1:0] vol_req;

    always_comb
    begin
        lo         = band_reg ? cfg.fm_low  : cfg.am_low;
        hi         = band_reg ? cfg.fm_high : cfg.am_high;
        step       = band_reg ? cfg.fm_step : cfg.am_step;
        last_cur   = band_reg ? last_fm_reg : last_am_reg;
        last_other = band_reg ? last_am_reg : last_fm_reg;
        idx_ok     = {1'b0, cmd.preset_index} < (IDX_W+1)'(PRESET_COUNT);
        pidx       = cmd.preset_index[PIDX_W-1:0];
        preset_rd  = band_reg ? fm_preset_reg[pidx] : am_preset_reg[pidx];
        up_sum     = {1'b0, station_reg} + (STATION_W+1)'(step);
        vol_req    = cmd.volume_value;

        power_next     = power_reg;
        band_next      = band_reg;
        station_next   = station_reg;
        volume_next    = volume_reg;
        saved_vol_next = saved_vol_reg;
        last_am_next   = last_am_reg;
        last_fm_next   = last_fm_reg;
        preset_we      = 1'b0;
        status         = ST_OK;

        case (cmd.req_type)
            REQ_POWER:
            begin
                power_next = ~power_reg;
                if (power_reg)
                begin
                    saved_vol_next = volume_reg;
                    volume_next    = '0;
                end
                else
                begin
                    volume_next  = saved_vol_reg;
                    station_next = last_cur;
                end
            end
            REQ_VOLUME:
            begin
                if (vol_req[VREQ_W-1])
                begin
                    volume_next = '0;
                    status      = ST_LOW;
                end
                else if (vol_req[VREQ_W-2:0] > (VREQ_W-1)'(cfg.volume_max))
                begin
                    volume_next = cfg.volume_max;
                    status      = ST_HIGH;
                end
                else
                begin
                    volume_next = vol_req[VOL_W-1:0];
                end
            end
            REQ_BAND:
            begin
                // station follows the last one of the band switched to
                band_next    = ~band_reg;
                station_next = last_other;
            end
            REQ_STORE:
            begin
                if (idx_ok)
                    preset_we = 1'b1;
                else
                    status = ST_REJ;
            end
            REQ_RECALL, REQ_UP, REQ_DOWN:
            begin
                if (cmd.req_type == REQ_RECALL && !idx_ok)
                begin
                    status = ST_REJ;
                end
                else
                begin
                    if (cmd.req_type == REQ_RECALL)
                        station_next = preset_rd;
                    else if (cmd.req_type == REQ_UP)
                    begin
                        if (station_reg >= hi)
                            station_next = lo;
                        else if (up_sum[STATION_W])
                            station_next = '1;
                        else
                            station_next = up_sum[STATION_W-1:0];
                    end
                    else
                    begin
                        if (station_reg <= lo)
                            station_next = hi;
                        else if (station_reg > STATION_W'(step))
                            station_next = station_reg - STATION_W'(step);
                        else
                            station_next = '0;
                    end
                    if (band_reg)
                        last_fm_next = station_next;
                    else
                        last_am_next = station_next;
                end
            end
            REQ_TUNE:
            begin
                // direct tune leaves the band's last station alone
                if (cmd.station_value >= lo && cmd.station_value <= hi)
                    station_next = cmd.station_value;
                else
                    status = ST_REJ;
            end
            REQ_QUERY:
            begin
                status = ST_OK;
            end
            default:
            begin
                status = ST_REJ;
            end
        endcase

        res_next.powered    = power_next;
        res_next.band_fm    = band_next;
        res_next.station    = station_next;
        res_next.volume_now = volume_next;
        res_next.status     = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg     <= 1'b0;
            band_reg      <= 1'b0;
            station_reg   <= AM_LOW_RST;
            volume_reg    <= '0;
            saved_vol_reg <= '0;
            last_am_reg   <= AM_LOW_RST;
            last_fm_reg   <= FM_LOW_RST;
            for (int i = 0; i < PRESET_COUNT; i++)
            begin
                am_preset_reg[i] <= AM_LOW_RST;
                fm_preset_reg[i] <= FM_LOW_RST;
            end
        end
        else if (cmd_fire)
        begin
            power_reg     <= power_next;
            band_reg      <= band_next;
            station_reg   <= station_next;
            volume_reg    <= volume_next;
            saved_vol_reg <= saved_vol_next;
            last_am_reg   <= last_am_next;
            last_fm_reg   <= last_fm_next;
            if (preset_we)
            begin
                if (band_reg)
                    fm_preset_reg[pidx] <= station_reg;
                else
                    am_preset_reg[pidx] <= station_reg;
            end
        end
    end

endmodule

FILE: sv/radio_tuner_controller_top.sv
// radio_tuner_controller_top: stream wrapper, configuration registers and output register
// of the two-band tuner controller
// depends on rtc_pkg and rtc_core
//
// usage:
//  - commands enter on the s_axis channel, one word per command; the command code is
//    s_axis_tuser, its operands are packed in s_axis_tdata
//  - each command gives exactly one word on the m_axis channel: power, band, station,
//    volume and a status code, reflecting the state after the command
//  - an accepted command goes from the input register to the result register that
//    drives m_axis_tvalid; one command per cycle is sustained while m_axis_tready is
//    high, as the state update is one short pass of compare, add and select logic
//  - if the receiver stalls, the result word holds and one more command waits in the
//    input register; s_axis_tready drops only when both are full
//  - the config channel is always ready and may be written only while no command is
//    in flight; writes change band limits, steps and the volume clamp, not the state
//  - reset (rst_n low) returns registers to their defaults: power off, AM band,
//    station and presets at the AM/FM low limits, volume zero, both stages empty
module radio_tuner_controller_top #(
    parameter int PRESET_COUNT = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // volume_value[15:0], preset_index[19:16], station_value[30:20], zero fill
    input  logic [rtc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type[3:0]
    input  logic [rtc_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // powered[0], band_fm[1], station[12:2], volume_now[19:13], status[21:20], zero fill
    output logic [rtc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rtc_pkg::*;

    rtc_cfg_t cfg_reg;
    logic     in_valid_reg;
    rtc_cmd_t in_cmd_reg;
    logic     out_valid_reg;
    rtc_res_t out_res_reg;
    rtc_res_t res_next;
    logic     advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.am_low     <= AM_LOW_RST;
            cfg_reg.am_high    <= AM_HIGH_RST;
            cfg_reg.am_step    <= AM_STEP_RST;
            cfg_reg.fm_low     <= FM_LOW_RST;
            cfg_reg.fm_high    <= FM_HIGH_RST;
            cfg_reg.fm_step    <= FM_STEP_RST;
            cfg_reg.volume_max <= VOLUME_MAX_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_AM_LOW:     cfg_reg.am_low     <= cfg_data;
                CFG_AM_HIGH:    cfg_reg.am_high    <= cfg_data;
                CFG_AM_STEP:    cfg_reg.am_step    <= cfg_data[STEP_W-1:0];
                CFG_FM_LOW:     cfg_reg.fm_low     <= cfg_data;
                CFG_FM_HIGH:    cfg_reg.fm_high    <= cfg_data;
                CFG_FM_STEP:    cfg_reg.fm_step    <= cfg_data[STEP_W-1:0];
                CFG_VOLUME_MAX: cfg_reg.volume_max <= cfg_data[VOL_W-1:0];
                // power-on value only matters at reset, and reset restores it to off
                CFG_POWER_INIT: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg.req_type      <= s_axis_tuser[REQ_W-1:0];
            in_cmd_reg.volume_value  <= s_axis_tdata[15:0];
            in_cmd_reg.preset_index  <= s_axis_tdata[19:16];
            in_cmd_reg.station_value <= s_axis_tdata[30:20];
        end
        if (advance)
            out_res_reg <= res_next;
    end

    rtc_core #(
        .PRESET_COUNT(PRESET_COUNT)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd_fire (advance),
        .cmd      (in_cmd_reg),
        .res_next (res_next)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_res_reg.status, out_res_reg.volume_now,
                            out_res_reg.station, out_res_reg.band_fm, out_res_reg.powered};

endmodule

FILE: sv/rtc_checker.sv
// rtc_checker: port-level checks of the tuner controller, bound to the top level
// depends on rtc_pkg and radio_tuner_controller_top
module rtc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [rtc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import rtc_pkg::*;

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

    // with the output register empty the input side can never be blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output stage");

    // low clamp always leaves the volume at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[21:20] == ST_LOW |-> m_axis_tdata[19:13] == '0)
    else $error("low clamp with nonzero volume");

    // an empty output stage only fills through the input register from an accepted command
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result word without an accepted command");

endmodule

bind radio_tuner_controller_top rtc_checker u_rtc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for radio_tuner_controller_top, with directed and random commands
// depends on rtc_pkg and the tuner controller rtl
module testbench;

    import rtc_pkg::*;

    localparam int PRESET_COUNT    = 5;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 92;
    localparam int SETTLE_CYCLES   = 4;
    localparam int STALL_LIMIT     = 400;
    localparam int MAX_WAIT        = 13;

    localparam logic [REQ_W-1:0] REQ_UNUSED_MIN = 4'd9;
    localparam logic [REQ_W-1:0] REQ_UNUSED_MAX = 4'd15;

    typedef struct packed {
        rtc_cmd_t cmd;
        logic     typed;
        rtc_res_t res;
    } bench_row_t;

    // opening commands under the reset settings; typed rows carry their readout
    localparam bench_row_t DIRECTED [26] = '{
        '{'{REQ_QUERY,  16'd0,     4'd0,  11'd0},    1'b1, '{1'b0, 1'b0, 11'd530, 7'd0, ST_OK}},
        '{'{REQ_VOLUME, 16'h8000,  4'd0,  11'd0},    1'b1, '{1'b0, 1'b0, 11'd530, 7'd0, ST_LOW}},
        '{'{REQ_VOLUME, 16'h7fff,  4'd0,  11'd0},    1'b1, '{1'b0, 1'b0, 11'd530, 7'd100, ST_HIGH}},
        '{'{REQ_VOLUME, 16'd0,     4'd0,  11'd0},    1'b1, '{1'b0, 1'b0, 11'd530, 7'd0, ST_OK}},
        '{'{REQ_VOLUME, 16'd100,   4'd0,  11'd0},    1'b1, '{1'b0, 1'b0, 11'd530, 7'd100, ST_OK}},
        '{'{REQ_VOLUME, 16'd101,   4'd0,  11'd0},    1'b1, '{1'b0, 1'b0, 11'd530, 7'd100, ST_HIGH}},
        '{'{REQ_POWER,  16'd0,     4'd0,  11'd0},    1'b0, '0},
        '{'{REQ_VOLUME, 16'd55,    4'd0,  11'd0},    1'b0, '0},
        '{'{REQ_POWER,  16'd0,     4'd0,  11'd0},    1'b0, '0},
        '{'{REQ_POWER,  16'd0,     4'd0,  11'd0},    1'b0, '0},
        '{'{REQ_DOWN,   16'd0,     4'd0,  11'd0},    1'b0, '0},
        '{'{REQ_UP,     16'd0,     4'd0,  11'd0},    1'b0, '0},
        '{'{REQ_UP,     16'd0,     4'd0,  11'd0},    1'b0, '0},
        '{'{REQ_STORE,  16'd0,     4'd0,  11'd0},    1'b0, '0},
        '{'{REQ_STORE,  16'd0,     4'd15, 11'd0},    1'b0, '0},
        '{'{REQ_STORE,  16'd0,     4'd4,  11'd0},    1'b0, '0},
        '{'{REQ_RECALL, 16'd0,     4'd5,  11'd0},    1'b0, '0},
        '{'{REQ_RECALL, 16'd0,     4'd0,  11'd0},    1'b0, '0},
        '{'{REQ_TUNE,   16'd0,     4'd0,  11'd2047}, 1'b0, '0},
        '{'{REQ_TUNE,   16'd0,     4'd0,  11'd1000}, 1'b0, '0},
        '{'{REQ_TUNE,   16'd0,     4'd0,  11'd0},    1'b0, '0},
        '{'{REQ_BAND,   16'd0,     4'd0,  11'd0},    1'b0, '0},
        '{'{REQ_TUNE,   16'd0,     4'd0,  11'd1079}, 1'b0, '0},
        '{'{REQ_UP,     16'd0,     4'd0,  11'd0},    1'b0, '0},
        '{'{REQ_UNUSED_MAX, 16'd0, 4'd0,  11'd0},    1'b0, '0},
        '{'{REQ_UNUSED_MIN, 16'd0, 4'd0,  11'd0},    1'b0, '0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic [S_TUSER_W-1:0]   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    radio_tuner_controller_top #(
        .PRESET_COUNT(PRESET_COUNT)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // tuner settings and state as the bench expects them
    rtc_cfg_t              band_plan;
    logic                  pwr_on;
    logic                  on_fm;
    logic [STATION_W-1:0]  tuned;
    logic [VOL_W-1:0]      vol_level;
    logic [VOL_W-1:0]      vol_saved;
    logic [STATION_W-1:0]  last_am;
    logic [STATION_W-1:0]  last_fm;
    logic [STATION_W-1:0]  am_slots [PRESET_COUNT];
    logic [STATION_W-1:0]  fm_slots [PRESET_COUNT];

    rtc_res_t expected_readouts [$];
    int       commands_sent;
    int       readouts_checked;
    int       settings_applied;
    int       mismatches;
    int       idle_cycles;
    logic     calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // apply one command to the expected tuner state and return its readout
    function automatic rtc_res_t advance_tuner(rtc_cmd_t c);
        logic [STATION_W-1:0] lo;
        logic [STATION_W-1:0] hi;
        logic [STEP_W-1:0]    stp;
        logic [STATION_W:0]   sum;
        logic [STATUS_W-1:0]  st;
        int                   want_vol;
        rtc_res_t             r;
        lo  = on_fm ? band_plan.fm_low  : band_plan.am_low;
        hi  = on_fm ? band_plan.fm_high : band_plan.am_high;
        stp = on_fm ? band_plan.fm_step : band_plan.am_step;
        st  = ST_OK;
        case (c.req_type)
            REQ_POWER:
            begin
                if (pwr_on)
                begin
                    pwr_on    = 1'b0;
                    vol_saved = vol_level;
                    vol_level = '0;
                end
                else
                begin
                    pwr_on    = 1'b1;
                    vol_level = vol_saved;
                    tuned     = on_fm ? last_fm : last_am;
                end
            end
            REQ_VOLUME:
            begin
                want_vol = int'(signed'(c.volume_value));
                if (want_vol < 0)
                begin
                    vol_level = '0;
                    st        = ST_LOW;
                end
                else if (want_vol > int'(band_plan.volume_max))
                begin
                    vol_level = band_plan.volume_max;
                    st        = ST_HIGH;
                end
                else
                    vol_level = VOL_W'(want_vol);
            end
            REQ_BAND:
            begin
                on_fm = ~on_fm;
                tuned = on_fm ? last_fm : last_am;
            end
            REQ_STORE:
            begin
                if (c.preset_index < PRESET_COUNT)
                begin
                    if (on_fm)
                        fm_slots[c.preset_index] = tuned;
                    else
                        am_slots[c.preset_index] = tuned;
                end
                else
                    st = ST_REJ;
            end
            REQ_RECALL:
            begin
                if (c.preset_index < PRESET_COUNT)
                    tuned = on_fm ? fm_slots[c.preset_index] : am_slots[c.preset_index];
                else
                    st = ST_REJ;
            end
            REQ_UP:
            begin
                if (tuned >= hi)
                    tuned = lo;
                else
                begin
                    sum   = {1'b0, tuned} + (STATION_W + 1)'(stp);
                    tuned = sum[STATION_W] ? '1 : sum[STATION_W-1:0];
                end
            end
            REQ_DOWN:
            begin
                if (tuned <= lo)
                    tuned = hi;
                else
                    tuned = (tuned > stp) ? tuned - STATION_W'(stp) : '0;
            end
            REQ_TUNE:
            begin
                if (c.station_value >= lo && c.station_value <= hi)
                    tuned = c.station_value;
                else
                    st = ST_REJ;
            end
            REQ_QUERY: ;
            default: st = ST_REJ;
        endcase
        // recall and scans carry the band's last station along; a direct tune does not
        if (c.req_type inside {REQ_RECALL, REQ_UP, REQ_DOWN} && st == ST_OK)
        begin
            if (on_fm)
                last_fm = tuned;
            else
                last_am = tuned;
        end
        r.powered    = pwr_on;
        r.band_fm    = on_fm;
        r.station    = tuned;
        r.volume_now = vol_level;
        r.status     = st;
        return r;
    endfunction

    function automatic rtc_cmd_t draw_command();
        rtc_cmd_t             c;
        int unsigned          pick;
        logic [STATION_W-1:0] lo;
        logic [STATION_W-1:0] hi;
        lo = on_fm ? band_plan.fm_low  : band_plan.am_low;
        hi = on_fm ? band_plan.fm_high : band_plan.am_high;
        c.volume_value  = VREQ_W'($urandom);
        c.preset_index  = IDX_W'($urandom);
        c.station_value = STATION_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 8)
            c.req_type = REQ_POWER;
        else if (pick < 22)
        begin
            c.req_type = REQ_VOLUME;
            case ($urandom_range(0, 3))
                0, 1: c.volume_value = VREQ_W'($urandom_range(0, band_plan.volume_max));
                2:    c.volume_value = VREQ_W'(band_plan.volume_max) + VREQ_W'($urandom_range(1, 2));
                default: ;
            endcase
        end
        else if (pick < 30)
            c.req_type = REQ_BAND;
        else if (pick < 50)
        begin
            c.req_type = (pick < 40) ? REQ_STORE : REQ_RECALL;
            if ($urandom_range(0, 3) != 0)
                c.preset_index = IDX_W'($urandom_range(0, PRESET_COUNT - 1));
        end
        else if (pick < 67)
            c.req_type = REQ_UP;
        else if (pick < 84)
            c.req_type = REQ_DOWN;
        else if (pick < 94)
        begin
            c.req_type = REQ_TUNE;
            if (lo <= hi && $urandom_range(0, 3) != 0)
                c.station_value = STATION_W'($urandom_range(lo, hi));
        end
        else if (pick < 97)
            c.req_type = REQ_QUERY;
        else
            c.req_type = REQ_W'($urandom_range(REQ_UNUSED_MIN, REQ_UNUSED_MAX));
        return c;
    endfunction

    task automatic issue_command(rtc_cmd_t c);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, c.station_value, c.preset_index, c.volume_value};
        s_axis_tuser  <= c.req_type;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_readouts.push_back(advance_tuner(c));
        commands_sent++;
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        // the power-on value takes effect only at reset, which restores it to off
        case (idx)
            CFG_AM_LOW:     band_plan.am_low     = val;
            CFG_AM_HIGH:    band_plan.am_high    = val;
            CFG_AM_STEP:    band_plan.am_step    = val[STEP_W-1:0];
            CFG_FM_LOW:     band_plan.fm_low     = val;
            CFG_FM_HIGH:    band_plan.fm_high    = val;
            CFG_FM_STEP:    band_plan.fm_step    = val[STEP_W-1:0];
            CFG_VOLUME_MAX: band_plan.volume_max = val[VOL_W-1:0];
            CFG_POWER_INIT: ;
            default: ;
        endcase
    endtask

    // result receiver: random stall before each word unless calm is set
    initial
    begin : readout_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin : readout_check
        rtc_res_t want;
        rtc_res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.powered    = m_axis_tdata[0];
            got.band_fm    = m_axis_tdata[1];
            got.station    = m_axis_tdata[12:2];
            got.volume_now = m_axis_tdata[19:13];
            got.status     = m_axis_tdata[21:20];
            if (expected_readouts.size() == 0)
            begin
                $error("readout word with no command outstanding: %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_readouts.pop_front();
                readouts_checked++;
                if (got.powered !== want.powered)
                begin
                    $error("powered: expected %0d, got %0d", want.powered, got.powered);
                    mismatches++;
                end
                if (got.band_fm !== want.band_fm)
                begin
                    $error("band_fm: expected %0d, got %0d", want.band_fm, got.band_fm);
                    mismatches++;
                end
                if (got.station !== want.station)
                begin
                    $error("station: expected %0d, got %0d", want.station, got.station);
                    mismatches++;
                end
                if (got.volume_now !== want.volume_now)
                begin
                    $error("volume_now: expected %0d, got %0d", want.volume_now, got.volume_now);
                    mismatches++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles where no channel moves a word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        rtc_cmd_t   c;
        rtc_cfg_t   next_plan;
        logic       next_power;
        int         run;
        int         n;
        int         kind;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        commands_sent = 0;
        settings_applied = 1;
        calm          = 1'b0;

        band_plan.am_low     = AM_LOW_RST;
        band_plan.am_high    = AM_HIGH_RST;
        band_plan.am_step    = AM_STEP_RST;
        band_plan.fm_low     = FM_LOW_RST;
        band_plan.fm_high    = FM_HIGH_RST;
        band_plan.fm_step    = FM_STEP_RST;
        band_plan.volume_max = VOLUME_MAX_RST;
        pwr_on     = 1'b0;
        on_fm      = 1'b0;
        tuned      = AM_LOW_RST;
        vol_level  = '0;
        vol_saved  = '0;
        last_am    = AM_LOW_RST;
        last_fm    = FM_LOW_RST;
        for (int i = 0; i < PRESET_COUNT; i++)
        begin
            am_slots[i] = AM_LOW_RST;
            fm_slots[i] = FM_LOW_RST;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            issue_command(DIRECTED[i].cmd);
            // the state still moves through the predictor; the readout is the typed one
            if (DIRECTED[i].typed)
                expected_readouts[$] = DIRECTED[i].res;
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            s_axis_tvalid <= 1'b0;
            while (expected_readouts.size() != 0) @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);

            kind = phase % 5;
            case (kind)
                0:
                begin
                    next_plan.am_low     = STATION_W'($urandom_range(0, 1800));
                    next_plan.am_high    = next_plan.am_low + STATION_W'($urandom_range(0, 247));
                    next_plan.am_step    = STEP_W'($urandom_range(1, 63));
                    next_plan.fm_low     = STATION_W'($urandom_range(0, 1800));
                    next_plan.fm_high    = next_plan.fm_low + STATION_W'($urandom_range(0, 247));
                    next_plan.fm_step    = STEP_W'($urandom_range(1, 63));
                    next_plan.volume_max = VOL_W'($urandom_range(0, 127));
                    next_power           = 1'($urandom);
                end
                1:
                begin
                    // full span with the widest step: scans saturate at both ends
                    next_plan.am_low     = '0;
                    next_plan.am_high    = '1;
                    next_plan.am_step    = 6'd63;
                    next_plan.fm_low     = '0;
                    next_plan.fm_high    = '1;
                    next_plan.fm_step    = 6'd63;
                    next_plan.volume_max = 7'd127;
                    next_power           = 1'b1;
                end
                2:
                begin
                    // single-station AM band, inverted FM band, volume locked at zero
                    next_plan.am_low     = STATION_W'($urandom_range(0, 2047));
                    next_plan.am_high    = next_plan.am_low;
                    next_plan.am_step    = 6'd1;
                    next_plan.fm_low     = '1;
                    next_plan.fm_high    = '0;
                    next_plan.fm_step    = 6'd1;
                    next_plan.volume_max = '0;
                    next_power           = 1'b0;
                end
                3:
                begin
                    next_plan.am_low     = STATION_W'($urandom);
                    next_plan.am_high    = STATION_W'($urandom);
                    next_plan.am_step    = STEP_W'($urandom_range(1, 63));
                    next_plan.fm_low     = STATION_W'($urandom);
                    next_plan.fm_high    = STATION_W'($urandom);
                    next_plan.fm_step    = STEP_W'($urandom_range(1, 63));
                    next_plan.volume_max = VOL_W'($urandom);
                    next_power           = 1'($urandom);
                end
                default:
                begin
                    next_plan.am_low     = AM_LOW_RST;
                    next_plan.am_high    = AM_HIGH_RST;
                    next_plan.am_step    = AM_STEP_RST;
                    next_plan.fm_low     = FM_LOW_RST;
                    next_plan.fm_high    = FM_HIGH_RST;
                    next_plan.fm_step    = FM_STEP_RST;
                    next_plan.volume_max = VOLUME_MAX_RST;
                    next_power           = 1'b0;
                end
            endcase

            write_register(CFG_AM_LOW,     next_plan.am_low);
            write_register(CFG_AM_HIGH,    next_plan.am_high);
            write_register(CFG_AM_STEP,    CFG_DATA_W'(next_plan.am_step));
            write_register(CFG_FM_LOW,     next_plan.fm_low);
            write_register(CFG_FM_HIGH,    next_plan.fm_high);
            write_register(CFG_FM_STEP,    CFG_DATA_W'(next_plan.fm_step));
            write_register(CFG_VOLUME_MAX, CFG_DATA_W'(next_plan.volume_max));
            write_register(CFG_POWER_INIT, CFG_DATA_W'(next_power));
            cfg_valid <= 1'b0;
            settings_applied++;
            calm = 1'b0;

            n = 0;
            if (kind == 1)
            begin
                c          = draw_command();
                c.req_type = REQ_UP;
                repeat (34) issue_command(c);
                c.req_type = REQ_DOWN;
                repeat (34) issue_command(c);
                n = 68;
            end

            while (n < ITEMS_PER_PHASE)
            begin
                c   = draw_command();
                run = 1;
                // occasional scan runs to walk across the band and hit the wraps
                if ($urandom_range(0, 9) == 0)
                begin
                    run        = $urandom_range(2, 40);
                    c.req_type = $urandom_range(0, 1) ? REQ_UP : REQ_DOWN;
                end
                repeat (run)
                begin
                    issue_command(c);
                    if ($urandom_range(0, 39) == 0)
                        calm = ~calm;
                end
                n += run;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_readouts.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d commands and %0d readouts over %0d register settings,",
                 commands_sent, readouts_checked, settings_applied);
        $display("including full-span, single-station and inverted bands and both volume limits");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
